@@ hw/rtl/mm_pkg.sv @@
// Shared types and constants for the matrix multiply block.
// Holds field widths, opcodes, register indexes, the cell tag struct and the store write struct.
// No dependencies.
`default_nettype none
package mm_pkg;

	localparam int unsigned IDX_W     = 3;   // row and column fields
	localparam int unsigned DIM_W     = 4;   // size registers
	localparam int unsigned VALUE_W   = 16;  // input element field
	localparam int unsigned PRODUCT_W = 36;  // result field
	localparam int unsigned OP_W      = 2;
	localparam int unsigned REG_IDX_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} mm_op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} mm_reg_t;

	// Tag that travels down the cell chain with each partial sum
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} mm_tag_t;

	// Store write request broadcast to the cells
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic [IDX_W-1:0] a_idx;
		logic [IDX_W-1:0] b_idx;
	} mm_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/mm_if.sv @@
// Handshake interfaces of the matrix multiply block: input items,
// result items and configuration writes. Depends on mm_pkg.
`default_nettype none
interface mm_in_if;
	logic                            valid;
	logic                            ready;
	logic [mm_pkg::OP_W-1:0]         op;
	logic [mm_pkg::IDX_W-1:0]        row;
	logic [mm_pkg::IDX_W-1:0]        col;
	logic signed [mm_pkg::VALUE_W-1:0] value;
	modport source (output valid, op, row, col, value, input ready);
	modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface mm_out_if;
	logic                                valid;
	logic                                ready;
	logic [mm_pkg::IDX_W-1:0]            out_row;
	logic [mm_pkg::IDX_W-1:0]            out_col;
	logic signed [mm_pkg::PRODUCT_W-1:0] product;
	logic                                last;
	modport source (output valid, out_row, out_col, product, last, input ready);
	modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

interface mm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mm_pkg::REG_IDX_W-1:0]    index;
	logic [mm_pkg::DIM_W-1:0]        data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mm_cell.sv @@
// One multiply-accumulate cell of the chain. Holds column CELL_IDX of A
// and row CELL_IDX of B, adds its term to the passing partial sum.
// Depends on mm_pkg.
`default_nettype none
module mm_cell #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16,
	parameter int CELL_IDX   = 0
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire mm_pkg::mm_wr_t                      wr,
	input  wire logic [ELEM_WIDTH-1:0]               wr_data,
	input  wire logic [mm_pkg::DIM_W-1:0]            inner_dim,
	input  wire mm_pkg::mm_tag_t                     tag_in,
	input  wire logic signed [mm_pkg::PRODUCT_W-1:0] psum_in,
	output mm_pkg::mm_tag_t                          tag_out,
	output logic signed [mm_pkg::PRODUCT_W-1:0]      psum_out
);
	import mm_pkg::*;

	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PW = 2 * ELEM_WIDTH;
	localparam logic [DIM_W-1:0] CELL_K = DIM_W'(CELL_IDX);

	logic signed [ELEM_WIDTH-1:0] a_q [MAX_DIM];
	logic signed [ELEM_WIDTH-1:0] b_q [MAX_DIM];
	logic signed [ELEM_WIDTH-1:0] a_sel, b_sel;
	logic signed [PW-1:0]         prod_s1;
	logic signed [PRODUCT_W-1:0]  psum_s1, psum_s2;
	mm_tag_t                      tag_s1, tag_s2;

	// element stores, written by loads
	always_ff @(posedge clk) begin
		if (wr.wr_a) begin
			a_q[wr.a_idx[IW-1:0]] <= wr_data;
		end
		if (wr.wr_b) begin
			b_q[wr.b_idx[IW-1:0]] <= wr_data;
		end
	end

	// A[row][k] and B[k][col] for the item entering this cell
	assign a_sel = a_q[tag_in.row[IW-1:0]];
	assign b_sel = b_q[tag_in.col[IW-1:0]];

	// control: tags advance when the chain moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	// stage 1 multiplies, stage 2 accumulates when k is inside inner_dim
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a_sel * b_sel;
			psum_s1 <= psum_in;
			if (CELL_K < inner_dim) begin
				psum_s2 <= psum_s1 + PRODUCT_W'(prod_s1);
			end else begin
				psum_s2 <= psum_s1;
			end
		end
	end

	assign tag_out  = tag_s2;
	assign psum_out = psum_s2;

endmodule
`default_nettype wire

@@ hw/rtl/matrix_multiply.sv @@
// Top level of the matrix multiply block: size registers, load decode,
// result sequencer and the chain of mm_cell instances.
// Depends on mm_pkg, mm_if and mm_cell.
`default_nettype none
// C = A * B in signed Q8.8, results exact in Q16.16 over 36 bits. A load item
// (op 0 for A, op 1 for B) writes straight into the cells when taken; loads
// outside the current sizes are dropped. A compute item (op 2) issues one
// result position per cycle while the output is not stalled into a chain of
// MAX_DIM cells, cell k adding A[i][k]*B[k][j] to the running sum with one
// multiply stage and one add stage. Results leave one per cycle while the
// output is not stalled, rows_a*cols_b results in all. The whole chain holds
// while the output is stalled. No new item is taken until the result marked
// last has been delivered. Size writes clamp to 1..MAX_DIM.
module matrix_multiply #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mm_in_if.sink    in_ch,
	mm_out_if.source out_ch,
	mm_cfg_if.sink   cfg
);
	import mm_pkg::*;

	localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q, cfg_clamped;
	logic             busy_q, issuing_q, en, in_acc;
	logic [IDX_W-1:0] i_q, j_q;
	logic             i_end, j_end;
	mm_wr_t           wr_base;
	logic [ELEM_WIDTH-1:0] wr_data;
	mm_tag_t          tag_c [MAX_DIM+1];
	logic signed [PRODUCT_W-1:0] psum_c [MAX_DIM+1];

	// configuration: clamp into 1..MAX_DIM
	assign cfg.ready = 1'b1;
	always_comb begin
		if (cfg.data == '0) begin
			cfg_clamped = DIM_W'(1);
		end else if (cfg.data > MAX_D) begin
			cfg_clamped = MAX_D;
		end else begin
			cfg_clamped = cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= MAX_D;
			inner_dim_q <= MAX_D;
			cols_b_q    <= MAX_D;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROWS_A:    rows_a_q    <= cfg_clamped;
				REG_INNER_DIM: inner_dim_q <= cfg_clamped;
				REG_COLS_B:    cols_b_q    <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// input side: loads write the cells, compute starts the sequencer
	assign in_ch.ready = !busy_q;
	assign in_acc      = in_ch.valid && !busy_q;
	assign wr_data     = ELEM_WIDTH'(in_ch.value);

	always_comb begin
		wr_base.wr_a  = in_acc && (in_ch.op == OP_LOAD_A)
			&& ({1'b0, in_ch.row} < rows_a_q) && ({1'b0, in_ch.col} < inner_dim_q);
		wr_base.wr_b  = in_acc && (in_ch.op == OP_LOAD_B)
			&& ({1'b0, in_ch.row} < inner_dim_q) && ({1'b0, in_ch.col} < cols_b_q);
		wr_base.a_idx = in_ch.row;
		wr_base.b_idx = in_ch.col;
	end

	// chain moves unless a result waits at the output
	assign en    = !tag_c[MAX_DIM].valid || out_ch.ready;
	assign i_end = ({1'b0, i_q} == rows_a_q - DIM_W'(1));
	assign j_end = ({1'b0, j_q} == cols_b_q - DIM_W'(1));

	// sequencer: walks C in row-major order, one position per cycle while the chain moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			if (in_acc && in_ch.op == OP_COMPUTE) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				i_q       <= '0;
				j_q       <= '0;
			end else if (issuing_q && en) begin
				if (j_end) begin
					j_q <= '0;
					if (i_end) begin
						issuing_q <= 1'b0;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			if (out_ch.valid && out_ch.ready && out_ch.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		tag_c[0].valid = issuing_q;
		tag_c[0].row   = i_q;
		tag_c[0].col   = j_q;
		tag_c[0].last  = i_end && j_end;
	end
	assign psum_c[0] = '0;

	// the cell chain; cell k owns column k of A and row k of B
	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		mm_wr_t wr_k;
		always_comb begin
			wr_k      = wr_base;
			wr_k.wr_a = wr_base.wr_a && (in_ch.col == IDX_W'(k));
			wr_k.wr_b = wr_base.wr_b && (in_ch.row == IDX_W'(k));
		end
		mm_cell #(
			.MAX_DIM    (MAX_DIM),
			.ELEM_WIDTH (ELEM_WIDTH),
			.CELL_IDX   (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.wr        (wr_k),
			.wr_data   (wr_data),
			.inner_dim (inner_dim_q),
			.tag_in    (tag_c[k]),
			.psum_in   (psum_c[k]),
			.tag_out   (tag_c[k+1]),
			.psum_out  (psum_c[k+1])
		);
	end

	// last cell's stage 2 is the output register
	assign out_ch.valid   = tag_c[MAX_DIM].valid;
	assign out_ch.out_row = tag_c[MAX_DIM].row;
	assign out_ch.out_col = tag_c[MAX_DIM].col;
	assign out_ch.last    = tag_c[MAX_DIM].last;
	assign out_ch.product = psum_c[MAX_DIM];

endmodule
`default_nettype wire
